### src/cellular_rule_table_matcher_macros.svh
// Assertion macros shared by the rule table matcher RTL.
`ifndef CELLULAR_RULE_TABLE_MATCHER_MACROS_SVH
`define CELLULAR_RULE_TABLE_MATCHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRTM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRTM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/crtm_pkg.sv
// Constants, types and helper functions of the cellular rule table matcher.
`timescale 1ns / 1ps

package crtm_pkg;

   localparam int MAX_STATES  = 64;
   localparam int MAX_WORDS   = 16;
   localparam int WORD_BITS   = 64;
   localparam int N_POSITIONS = 9;
   localparam int MASK_DEPTH  = N_POSITIONS * MAX_STATES * MAX_WORDS;
   localparam int RULE_DEPTH  = MAX_WORDS * WORD_BITS;

   localparam int STATE_W     = 6;
   localparam int POS_W       = 4;
   localparam int WORD_IDX_W  = $clog2(MAX_WORDS);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int MASK_ADDR_W = 14;
   localparam int RULE_ADDR_W = $clog2(RULE_DEPTH);
   localparam int WCOUNT_W    = 5;
   localparam int CMD_W       = 2;
   localparam int CSR_IDX_W   = 2;

   localparam int REQ_DATA_W  = 136;
   localparam int RSP_DATA_W  = 8;

   localparam int OFS_NW    = 0;
   localparam int OFS_N     = 6;
   localparam int OFS_NE    = 12;
   localparam int OFS_W     = 18;
   localparam int OFS_C     = 24;
   localparam int OFS_E     = 30;
   localparam int OFS_SW    = 36;
   localparam int OFS_S     = 42;
   localparam int OFS_SE    = 48;
   localparam int OFS_ADDR  = 54;
   localparam int OFS_DATA  = 68;

   localparam logic [CMD_W-1:0] CMD_EVAL = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MASK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RULE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MOORE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_COUNT = 2'd1;

   localparam logic [POS_W-1:0] LAST_POS_VN    = 4'd4;
   localparam logic [POS_W-1:0] LAST_POS_MOORE = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ENCODE,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [STATE_W-1:0] nw;
      logic [STATE_W-1:0] n;
      logic [STATE_W-1:0] ne;
      logic [STATE_W-1:0] w;
      logic [STATE_W-1:0] c;
      logic [STATE_W-1:0] e;
      logic [STATE_W-1:0] sw;
      logic [STATE_W-1:0] s;
      logic [STATE_W-1:0] se;
   } cells_type;

   // State of the neighbour that owns a given table position.
   function automatic logic [STATE_W-1:0] pos_state(input logic moore,
                                                    input logic [POS_W-1:0] pos,
                                                    input cells_type cells);
      logic [STATE_W-1:0] st;
      st = cells.c;
      if (moore) begin
         case (pos)
            4'd0: st = cells.c;
            4'd1: st = cells.n;
            4'd2: st = cells.ne;
            4'd3: st = cells.e;
            4'd4: st = cells.se;
            4'd5: st = cells.s;
            4'd6: st = cells.sw;
            4'd7: st = cells.w;
            4'd8: st = cells.nw;
            default: st = cells.c;
         endcase
      end else begin
         case (pos)
            4'd0: st = cells.c;
            4'd1: st = cells.n;
            4'd2: st = cells.e;
            4'd3: st = cells.s;
            4'd4: st = cells.w;
            default: st = cells.c;
         endcase
      end
      return st;
   endfunction

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] hit);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### src/cellular_rule_table_matcher.sv
// An evaluate request scans each word over 5 (von Neumann) or 9 (Moore) positions, up to the
// configured word count, stopping at the first word with a rule hit; with no words in use it
// goes straight to emit. One mask word is read per cycle from the single mask memory port.
// Write requests go straight into the tables; one request is in flight at a time. Tables are
// undefined until written. Synchronous reset idles control, sets Moore mode, zeroes word count.
`timescale 1ns / 1ps
`include "cellular_rule_table_matcher_macros.svh"

module cellular_rule_table_matcher (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // cell_nw, cell_n, cell_ne, cell_w, cell_c, cell_e, cell_sw, cell_s, cell_se,
   // table_addr, table_data, zero padding
   input  logic [crtm_pkg::REQ_DATA_W-1:0]       req_tdata,
   // cmd
   input  logic [crtm_pkg::CMD_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // next_state, zero padding
   output logic [crtm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // matched
   output logic                                  rsp_tuser,
   input  logic                                  csr_we,
   input  logic [crtm_pkg::CSR_IDX_W-1:0]        csr_addr,
   input  logic [crtm_pkg::WCOUNT_W-1:0]         csr_wdata
);

   logic [crtm_pkg::WORD_BITS-1:0] mask_mem [crtm_pkg::MASK_DEPTH];
   logic [crtm_pkg::STATE_W-1:0]   rule_mem [crtm_pkg::RULE_DEPTH];

   crtm_pkg::state_type state_ff, state_in;

   logic                               moore_ff;
   logic [crtm_pkg::WCOUNT_W-1:0]      word_count_ff;
   crtm_pkg::cells_type                cells_ff, cells_in;
   logic [crtm_pkg::POS_W-1:0]         iss_pos_ff, iss_pos_in;
   logic [crtm_pkg::WORD_IDX_W-1:0]    iss_word_ff, iss_word_in;
   logic                               rd_valid_ff, rd_valid_in;
   logic [crtm_pkg::POS_W-1:0]         rd_pos_ff;
   logic [crtm_pkg::WORD_IDX_W-1:0]    rd_word_ff;
   logic [crtm_pkg::WORD_BITS-1:0]     mask_q_ff;
   logic [crtm_pkg::WORD_BITS-1:0]     acc_ff, acc_in;
   logic [crtm_pkg::WORD_BITS-1:0]     hit_ff, hit_in;
   logic [crtm_pkg::WORD_IDX_W-1:0]    hit_word_ff, hit_word_in;
   logic [crtm_pkg::STATE_W-1:0]       rule_q_ff;
   logic [crtm_pkg::STATE_W-1:0]       res_state_ff, res_state_in;
   logic                               res_matched_ff, res_matched_in;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [crtm_pkg::STATE_W-1:0]       rsp_state_ff, rsp_state_in;
   logic                               rsp_matched_ff, rsp_matched_in;

   logic                               accept;
   logic [crtm_pkg::CMD_W-1:0]         req_cmd;
   logic [crtm_pkg::MASK_ADDR_W-1:0]   req_addr;
   logic [crtm_pkg::WORD_BITS-1:0]     req_data;
   crtm_pkg::cells_type                req_cells;
   logic                               mask_we, rule_we;
   logic [crtm_pkg::WCOUNT_W-1:0]      words_sat, words_m1;
   logic [crtm_pkg::POS_W-1:0]         last_pos;
   logic [crtm_pkg::MASK_ADDR_W-1:0]   mask_raddr;
   logic [crtm_pkg::RULE_ADDR_W-1:0]   rule_raddr;
   logic [crtm_pkg::WORD_BITS-1:0]     acc_next;
   logic                               word_end, final_word, hit_any;

   assign req_cmd   = req_tuser;
   assign req_addr  = req_tdata[crtm_pkg::OFS_ADDR +: crtm_pkg::MASK_ADDR_W];
   assign req_data  = req_tdata[crtm_pkg::OFS_DATA +: crtm_pkg::WORD_BITS];
   assign req_cells.nw = req_tdata[crtm_pkg::OFS_NW +: crtm_pkg::STATE_W];
   assign req_cells.n  = req_tdata[crtm_pkg::OFS_N  +: crtm_pkg::STATE_W];
   assign req_cells.ne = req_tdata[crtm_pkg::OFS_NE +: crtm_pkg::STATE_W];
   assign req_cells.w  = req_tdata[crtm_pkg::OFS_W  +: crtm_pkg::STATE_W];
   assign req_cells.c  = req_tdata[crtm_pkg::OFS_C  +: crtm_pkg::STATE_W];
   assign req_cells.e  = req_tdata[crtm_pkg::OFS_E  +: crtm_pkg::STATE_W];
   assign req_cells.sw = req_tdata[crtm_pkg::OFS_SW +: crtm_pkg::STATE_W];
   assign req_cells.s  = req_tdata[crtm_pkg::OFS_S  +: crtm_pkg::STATE_W];
   assign req_cells.se = req_tdata[crtm_pkg::OFS_SE +: crtm_pkg::STATE_W];

   assign req_tready = (state_ff == crtm_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign mask_we = accept && (req_cmd == crtm_pkg::CMD_MASK)
                    && (req_addr < crtm_pkg::MASK_ADDR_W'(crtm_pkg::MASK_DEPTH));
   assign rule_we = accept && (req_cmd == crtm_pkg::CMD_RULE)
                    && (req_addr < crtm_pkg::MASK_ADDR_W'(crtm_pkg::RULE_DEPTH));

   assign words_sat = (word_count_ff > crtm_pkg::WCOUNT_W'(crtm_pkg::MAX_WORDS))
                      ? crtm_pkg::WCOUNT_W'(crtm_pkg::MAX_WORDS) : word_count_ff;
   assign words_m1  = words_sat - crtm_pkg::WCOUNT_W'(1);
   assign last_pos  = moore_ff ? crtm_pkg::LAST_POS_MOORE : crtm_pkg::LAST_POS_VN;

   assign mask_raddr = {iss_pos_ff, crtm_pkg::pos_state(moore_ff, iss_pos_ff, cells_ff),
                        iss_word_ff};
   assign rule_raddr = {hit_word_ff, crtm_pkg::lowest_bit(hit_ff)};

   assign acc_next   = (rd_pos_ff == '0) ? mask_q_ff : (acc_ff & mask_q_ff);
   assign hit_any    = |acc_next;
   assign word_end   = rd_valid_ff && (rd_pos_ff == last_pos);
   assign final_word = ({1'b0, rd_word_ff} == words_m1);

   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[req_addr] <= req_data;
      end
      mask_q_ff <= mask_mem[mask_raddr];
   end

   always_ff @(posedge clock) begin
      if (rule_we) begin
         rule_mem[req_addr[crtm_pkg::RULE_ADDR_W-1:0]] <= req_data[crtm_pkg::STATE_W-1:0];
      end
      rule_q_ff <= rule_mem[rule_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= crtm_pkg::ST_IDLE;
         rd_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         moore_ff      <= 1'b1;
         word_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we && (csr_addr == crtm_pkg::CSR_MOORE_MODE)) begin
            moore_ff <= csr_wdata[0];
         end
         if (csr_we && (csr_addr == crtm_pkg::CSR_WORD_COUNT)) begin
            word_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cells_ff       <= cells_in;
      iss_pos_ff     <= iss_pos_in;
      iss_word_ff    <= iss_word_in;
      rd_pos_ff      <= iss_pos_ff;
      rd_word_ff     <= iss_word_ff;
      acc_ff         <= acc_in;
      hit_ff         <= hit_in;
      hit_word_ff    <= hit_word_in;
      res_state_ff   <= res_state_in;
      res_matched_ff <= res_matched_in;
      rsp_state_ff   <= rsp_state_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   always_comb begin
      state_in       = state_ff;
      cells_in       = cells_ff;
      iss_pos_in     = iss_pos_ff;
      iss_word_in    = iss_word_ff;
      rd_valid_in    = 1'b0;
      acc_in         = acc_ff;
      hit_in         = hit_ff;
      hit_word_in    = hit_word_ff;
      res_state_in   = res_state_ff;
      res_matched_in = res_matched_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_state_in   = rsp_state_ff;
      rsp_matched_in = rsp_matched_ff;

      case (state_ff)
         crtm_pkg::ST_IDLE: begin
            iss_pos_in  = '0;
            iss_word_in = '0;
            if (accept && (req_cmd == crtm_pkg::CMD_EVAL)) begin
               cells_in       = req_cells;
               res_state_in   = req_cells.c;
               res_matched_in = 1'b0;
               if (words_sat == '0) begin
                  state_in = crtm_pkg::ST_EMIT;
               end else begin
                  state_in = crtm_pkg::ST_SCAN;
               end
            end
         end
         crtm_pkg::ST_SCAN: begin
            rd_valid_in = 1'b1;
            if (iss_pos_ff == last_pos) begin
               iss_pos_in  = '0;
               iss_word_in = iss_word_ff + crtm_pkg::WORD_IDX_W'(1);
            end else begin
               iss_pos_in = iss_pos_ff + crtm_pkg::POS_W'(1);
            end
            if (rd_valid_ff) begin
               acc_in = acc_next;
            end
            if (word_end && hit_any) begin
               rd_valid_in = 1'b0;
               hit_in      = acc_next;
               hit_word_in = rd_word_ff;
               state_in    = crtm_pkg::ST_ENCODE;
            end else if (word_end && final_word) begin
               rd_valid_in    = 1'b0;
               res_state_in   = cells_ff.c;
               res_matched_in = 1'b0;
               state_in       = crtm_pkg::ST_EMIT;
            end
         end
         crtm_pkg::ST_ENCODE: begin
            state_in = crtm_pkg::ST_LOOKUP;
         end
         crtm_pkg::ST_LOOKUP: begin
            res_state_in   = rule_q_ff;
            res_matched_in = 1'b1;
            state_in       = crtm_pkg::ST_EMIT;
         end
         crtm_pkg::ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in  = 1'b1;
               rsp_state_in   = res_state_ff;
               rsp_matched_in = res_matched_ff;
               state_in       = crtm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crtm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(crtm_pkg::RSP_DATA_W - crtm_pkg::STATE_W){1'b0}}, rsp_state_ff};
   assign rsp_tuser  = rsp_matched_ff;

   `CRTM_ASSERT_SAME(a_read_only_from_scan, clock, reset, rd_valid_ff,
      $past(state_ff) == crtm_pkg::ST_SCAN, "mask data returned outside a scan")
   `CRTM_ASSERT_SAME(a_read_pos_in_range, clock, reset, rd_valid_ff,
      rd_pos_ff <= last_pos, "mask read position beyond the neighbourhood")
   `CRTM_ASSERT_SAME(a_encode_has_hit, clock, reset, state_ff == crtm_pkg::ST_ENCODE,
      hit_ff != '0, "rule lookup started without a matching rule")
   `CRTM_ASSERT_NEXT(a_emit_loads_rsp, clock, reset,
      (state_ff == crtm_pkg::ST_EMIT) && (!rsp_tvalid_ff || rsp_tready),
      rsp_tvalid_ff && (state_ff == crtm_pkg::ST_IDLE), "response not loaded on emit")

endmodule
